>>> src/icv_pkg.sv
// Package for the image container verifier: sizes, register indexes, status codes,
// the configuration struct and the byte-wide CRC-32/MPEG-2 update.
// Depends on nothing; used by icv_regs, image_container_verifier and icv_checker.
package icv_pkg;

	localparam int unsigned MaxImageBytes = 16777216;
	localparam int unsigned OffsetW = $clog2(MaxImageBytes + 1);
	localparam int unsigned CapW = 25;
	localparam int unsigned CapacityReset = 16777216;
	localparam int unsigned LenBytes = 4;
	localparam int unsigned HeaderBytes = 16;
	localparam int unsigned CrcBytes = 4;
	localparam int unsigned MinImageBytes = 20;
	localparam int unsigned MakerEnd = 7;
	localparam int unsigned HardwareEnd = 11;
	localparam int unsigned VariantEnd = 15;
	localparam logic [31:0] CrcPoly = 32'h04C1_1DB7;
	localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
	localparam int unsigned AddrW = 4;

	typedef enum logic [1:0] {
		REG_MAKER    = 2'd0,
		REG_HARDWARE = 2'd1,
		REG_VARIANT  = 2'd2,
		REG_CAPACITY = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_SHORT     = 3'd1,
		ST_LEN_LARGE = 3'd2,
		ST_IDENTITY  = 3'd3,
		ST_CRC       = 3'd4,
		ST_CAPACITY  = 3'd5
	} status_t;

	typedef struct packed {
		logic [31:0]     maker;
		logic [31:0]     hardware;
		logic [31:0]     variant;
		logic [CapW-1:0] capacity;
	} cfg_t;

	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		logic        top;
		c = crc;
		for (int i = 7; i >= 0; i--) begin
			top = c[31] ^ b[i];
			c = {c[30:0], 1'b0};
			if (top) begin
				c = c ^ CrcPoly;
			end
		end
		return c;
	endfunction

endpackage

>>> src/icv_byte_if.sv
// Channel interfaces of the image container verifier: image bytes in, results out.
// Depends on nothing.
interface icv_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, in_byte, in_last, input ready);
	modport sink (input valid, in_byte, in_last, output ready);
	modport mon (input valid, ready, in_byte, in_last);
endinterface

interface icv_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_payload;
	logic        done_res;
	logic [2:0]  status;
	logic [31:0] payload_length;

	modport source (output valid, out_byte, is_payload, done_res, status, payload_length,
		input ready);
	modport sink (input valid, out_byte, is_payload, done_res, status, payload_length,
		output ready);
	modport mon (input valid, ready, out_byte, is_payload, done_res, status, payload_length);
endinterface

>>> src/icv_regs.sv
// APB-style configuration registers of the image container verifier.
// Depends on icv_pkg for the register indexes and the configuration struct.
module icv_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [icv_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output icv_pkg::cfg_t              cfg
);
	import icv_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.maker    <= '0;
			cfg_q.hardware <= '0;
			cfg_q.variant  <= '0;
			cfg_q.capacity <= CapW'(CapacityReset);
		end else if (wr_en) begin
			unique case (idx)
				REG_MAKER:    cfg_q.maker    <= pwdata;
				REG_HARDWARE: cfg_q.hardware <= pwdata;
				REG_VARIANT:  cfg_q.variant  <= pwdata;
				REG_CAPACITY: cfg_q.capacity <= pwdata[CapW-1:0];
				default:      cfg_q.maker    <= cfg_q.maker;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MAKER:    prdata = cfg_q.maker;
			REG_HARDWARE: prdata = cfg_q.hardware;
			REG_VARIANT:  prdata = cfg_q.variant;
			REG_CAPACITY: prdata = 32'(cfg_q.capacity);
			default:      prdata = '0;
		endcase
	end
endmodule

>>> src/image_container_verifier.sv
// Image container verifier: checks size, length, identity words, CRC and capacity of a byte stream.
// Pipeline: each byte passes through an input register and then a result register.
// Throughput: one byte per cycle unless the result side stalls; the two registers part the sides.
// Reset clears the pipeline and the parse state and returns the registers to reset values.
// Depends on icv_pkg, icv_byte_if, icv_res_if and icv_regs.
module image_container_verifier (
	input  logic                       clk,
	input  logic                       arst_n,
	icv_byte_if.sink                   image,
	icv_res_if.source                  result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [icv_pkg::AddrW-1:0]  paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import icv_pkg::*;

	cfg_t cfg;

	icv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	logic [7:0]  byte_s2;
	logic        payload_s2;
	logic        done_s2;
	status_t     status_s2;
	logic [31:0] length_s2;

	logic [OffsetW-1:0] offset_q;
	logic [31:0]        length_q;
	logic [31:0]        ident_q;
	logic               ident_ok_q;
	logic [31:0]        crc_q;
	logic [31:0]        stored_q;

	logic               adv;
	logic               in_image;
	logic [32:0]        off_w;
	logic [32:0]        len_end;
	logic               in_len;
	logic               in_ident;
	logic               in_crc;
	logic               in_pay;
	logic               in_stored;
	logic [OffsetW-1:0] offset_n;
	logic [31:0]        length_n;
	logic [31:0]        ident_n;
	logic               ident_ok_n;
	logic [31:0]        crc_n;
	logic [31:0]        stored_n;
	logic [OffsetW-1:0] total;
	status_t            status_n;

	assign adv         = valid_s1 && (!valid_s2 || result.ready);
	assign image.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (image.ready) begin
				valid_s1 <= image.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (image.valid && image.ready) begin
			byte_s1 <= image.in_byte;
			last_s1 <= image.in_last;
		end
		if (adv) begin
			byte_s2    <= byte_s1;
			payload_s2 <= in_image && in_pay;
			done_s2    <= last_s1;
			status_s2  <= last_s1 ? status_n : ST_OK;
			length_s2  <= last_s1 ? length_n : '0;
		end
	end

	always_comb begin
		in_image  = offset_q < OffsetW'(MaxImageBytes);
		off_w     = 33'(offset_q);
		len_end   = 33'(length_q) + 33'(HeaderBytes);
		in_len    = offset_q < OffsetW'(LenBytes);
		in_ident  = !in_len && offset_q < OffsetW'(HeaderBytes);
		in_crc    = !in_len && off_w < len_end;
		in_pay    = offset_q >= OffsetW'(HeaderBytes) && off_w < len_end;
		in_stored = off_w >= len_end && off_w < len_end + 33'(CrcBytes);

		offset_n   = offset_q;
		length_n   = length_q;
		ident_n    = ident_q;
		ident_ok_n = ident_ok_q;
		crc_n      = crc_q;
		stored_n   = stored_q;
		if (in_image) begin
			offset_n = offset_q + 1'b1;
			if (in_len) begin
				length_n = {length_q[23:0], byte_s1};
			end
			if (in_ident) begin
				ident_n = {ident_q[23:0], byte_s1};
			end
			if ((offset_q == OffsetW'(MakerEnd) && ident_n != cfg.maker) ||
				(offset_q == OffsetW'(HardwareEnd) && ident_n != cfg.hardware) ||
				(offset_q == OffsetW'(VariantEnd) && ident_n != cfg.variant)) begin
				ident_ok_n = 1'b0;
			end
			if (in_crc) begin
				crc_n = crc32_byte(crc_q, byte_s1);
			end
			if (in_stored) begin
				stored_n = {stored_q[23:0], byte_s1};
			end
		end

		total = in_image ? offset_q + 1'b1 : OffsetW'(MaxImageBytes);
		priority if (total < OffsetW'(MinImageBytes)) begin
			status_n = ST_SHORT;
		end else if (length_n > 32'(total - OffsetW'(MinImageBytes))) begin
			status_n = ST_LEN_LARGE;
		end else if (!ident_ok_n) begin
			status_n = ST_IDENTITY;
		end else if (crc_n != stored_n) begin
			status_n = ST_CRC;
		end else if (length_n > 32'(cfg.capacity)) begin
			status_n = ST_CAPACITY;
		end else begin
			status_n = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			length_q   <= '0;
			ident_q    <= '0;
			ident_ok_q <= 1'b1;
			crc_q      <= CrcInit;
			stored_q   <= '0;
		end else if (adv) begin
			if (last_s1) begin
				offset_q   <= '0;
				length_q   <= '0;
				ident_q    <= '0;
				ident_ok_q <= 1'b1;
				crc_q      <= CrcInit;
				stored_q   <= '0;
			end else begin
				offset_q   <= offset_n;
				length_q   <= length_n;
				ident_q    <= ident_n;
				ident_ok_q <= ident_ok_n;
				crc_q      <= crc_n;
				stored_q   <= stored_n;
			end
		end
	end

	assign result.valid          = valid_s2;
	assign result.out_byte       = byte_s2;
	assign result.is_payload     = payload_s2;
	assign result.done_res       = done_s2;
	assign result.status         = 3'(status_s2);
	assign result.payload_length = length_s2;
endmodule

>>> src/icv_checker.sv
// Port-level assertions for the image container verifier, bound to its top level.
// Depends on icv_pkg, icv_byte_if and icv_res_if.
module icv_checker (
	input logic       clk,
	input logic       arst_n,
	icv_byte_if.sink  image,
	icv_res_if.source result
);
	import icv_pkg::*;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.out_byte) &&
		$stable(result.status) && $stable(result.payload_length))
		else $error("Stalled result transfer changed.");

	a_ready_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!image.ready |-> result.valid && !result.ready)
		else $error("Input held off while the result side was free.");

	a_verdict_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.done_res |-> result.status == 3'(ST_OK) &&
		result.payload_length == 32'd0)
		else $error("Verdict shown on a byte that is not the last.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.status <= 3'(ST_CAPACITY))
		else $error("Status code out of range.");
endmodule

bind image_container_verifier icv_checker u_icv_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.image  (image),
	.result (result)
);
